FILE: rtl/msp_pkg.sv
`default_nettype none

package msp_pkg;

    // fixed field widths of the request and result channels
    localparam int SEL_W    = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int EXT_W    = 64;

    // default sizes
    localparam int DEF_NUM_STACKS = 4;
    localparam int DEF_POOL_DEPTH = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // request modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic data_we;
        logic link_we;
    } t_mem_ctl;

    typedef struct packed {
        logic [VAL_W-1:0]    pop_value;
        logic [STATUS_W-1:0] status;
        logic                stack_empty;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/msp_pool_mem.sv
`default_nettype none

module msp_pool_mem
    import msp_pkg::*;
#(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int AW         = $clog2(POOL_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire t_mem_ctl              i_ctl,
    input  wire logic [AW-1:0]         i_rd_addr,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    input  wire logic [AW:0]           i_wr_link,
    output      logic [DATA_WIDTH-1:0] o_rd_data,
    output      logic [AW:0]           o_rd_link
);

    // slot values and next-slot pointers ({valid, index})
    logic [DATA_WIDTH-1:0] data_mem [POOL_DEPTH];
    logic [AW:0]           link_mem [POOL_DEPTH];

    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [AW:0]           r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= data_mem[i_rd_addr];
            r_rd_link <= link_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.data_we) begin
            data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            link_mem[i_wr_addr] <= i_wr_link;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_link = r_rd_link;

endmodule

`default_nettype wire

FILE: rtl/msp_ctrl.sv
`default_nettype none

module msp_ctrl
    import msp_pkg::*;
#(
    parameter int NUM_STACKS = DEF_NUM_STACKS,
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int AW         = $clog2(POOL_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request side
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic                  i_mode,
    input  wire logic [SEL_W-1:0]      i_stack_sel,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    // result side
    input  wire logic                  i_out_free,
    output      logic                  o_res_load,
    output      t_result               o_res,
    // pool memory
    output      t_mem_ctl              o_mem_ctl,
    output      logic [AW-1:0]         o_rd_addr,
    output      logic [AW-1:0]         o_wr_addr,
    output      logic [DATA_WIDTH-1:0] o_wr_data,
    output      logic [AW:0]           o_wr_link,
    input  wire logic [DATA_WIDTH-1:0] i_rd_data,
    input  wire logic [AW:0]           i_rd_link
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW = SW + SEL_W + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_idx;
    logic [AW-1:0]         r_head_idx [NUM_STACKS];
    logic [NUM_STACKS-1:0] r_head_vld;
    logic [AW-1:0]         r_free_idx;
    logic                  r_free_vld;

    // request captured at acceptance
    logic                  r_mode;
    logic [SW-1:0]         r_sel_idx;
    logic                  r_present;
    logic                  r_ok;
    logic [AW-1:0]         r_slot;
    logic                  r_head_cur_vld;
    logic [AW-1:0]         r_head_cur_idx;
    logic [DATA_WIDTH-1:0] r_val;

    logic                  w_accept;
    logic                  w_go;
    logic [CW-1:0]         w_sel_wide;
    logic [SW-1:0]         w_sel_idx;
    logic                  w_present;
    logic                  w_head_vld;
    logic [AW-1:0]         w_head_idx;
    logic                  w_ok;
    logic signed [EXT_W-1:0] w_push_ext;
    logic signed [DATA_WIDTH-1:0] w_rd_s;
    logic signed [EXT_W-1:0] w_rd_ext;
    logic                  w_clr_last;

    assign w_sel_wide = CW'(i_stack_sel);
    assign w_sel_idx  = w_sel_wide[SW-1:0];
    assign w_present  = (w_sel_wide < CW'(NUM_STACKS));
    assign w_head_vld = w_present ? r_head_vld[w_sel_idx] : 1'b0;
    assign w_head_idx = w_present ? r_head_idx[w_sel_idx] : '0;
    assign w_ok       = w_present && ((i_mode == MODE_POP) ? w_head_vld : r_free_vld);
    assign w_push_ext = EXT_W'(i_push_value);
    assign w_rd_s     = i_rd_data;
    assign w_rd_ext   = EXT_W'(w_rd_s);
    assign w_clr_last = (r_clr_idx == AW'(POOL_DEPTH - 1));

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_go       = (r_state == S_EXEC) && i_out_free;
    assign o_res_load = w_go;

    // memory port
    always_comb begin
        o_mem_ctl         = '0;
        o_mem_ctl.rd_en   = w_accept;
        o_rd_addr         = (i_mode == MODE_POP) ? w_head_idx : r_free_idx;
        o_wr_addr         = r_slot;
        o_wr_data         = r_val;
        o_wr_link         = {r_free_vld, r_free_idx};
        if (r_state == S_CLEAR) begin
            // initial free list: each slot links the next, last is null
            o_mem_ctl.link_we = 1'b1;
            o_wr_addr         = r_clr_idx;
            o_wr_link         = {!w_clr_last, r_clr_idx + AW'(1)};
        end else if (w_go && r_ok) begin
            o_mem_ctl.link_we = 1'b1;
            if (r_mode == MODE_PUSH) begin
                o_mem_ctl.data_we = 1'b1;
                o_wr_link         = {r_head_cur_vld, r_head_cur_idx};
            end
        end
    end

    // result
    always_comb begin
        o_res             = '0;
        o_res.stack_empty = 1'b1;
        if (r_mode == MODE_PUSH) begin
            o_res.status = r_ok ? ST_OK : ST_OVERFLOW;
            if (r_present) begin
                o_res.stack_empty = r_ok ? 1'b0 : !r_head_cur_vld;
            end
        end else begin
            if (r_ok) begin
                o_res.status      = ST_OK;
                o_res.pop_value   = w_rd_ext[VAL_W-1:0];
                o_res.stack_empty = !i_rd_link[AW];
            end else begin
                o_res.status    = ST_UNDERFLOW;
                o_res.pop_value = '1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_head_vld <= '0;
            r_free_idx <= '0;
            r_free_vld <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (w_go && r_ok) begin
                if (r_mode == MODE_PUSH) begin
                    r_free_vld <= i_rd_link[AW];
                    r_free_idx <= i_rd_link[AW-1:0];
                    r_head_vld[r_sel_idx] <= 1'b1;
                end else begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_slot;
                    r_head_vld[r_sel_idx] <= i_rd_link[AW];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode         <= i_mode;
            r_sel_idx      <= w_sel_idx;
            r_present      <= w_present;
            r_ok           <= w_ok;
            r_slot         <= o_rd_addr;
            r_head_cur_vld <= w_head_vld;
            r_head_cur_idx <= w_head_idx;
            r_val          <= w_push_ext[DATA_WIDTH-1:0];
        end
        if (w_go && r_ok) begin
            r_head_idx[r_sel_idx] <= (r_mode == MODE_PUSH) ? r_slot : i_rd_link[AW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/multi_stack_shared_pool.sv
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | i_valid / o_ready  | i_mode, i_stack_sel, i_push_value
// result    | out       | o_valid / i_ready  | o_pop_value, o_status, o_stack_empty
//
// for each request the acceptance edge issues one synchronous read of the
// data and link store (at the stack top for a pop, at the free-list head for a push),
// and the write-back edge, once the output register is free, writes the store back,
// updates the head pointers and loads the result; one request is in flight at a time,
// and o_ready is high whenever none is in flight, except during the reset sweep:
// after reset the link store is swept to its initial free list, with o_ready low
// a result waiting in the output register holds the block in its write-back cycle only
// when the following request's result is due, so one request is taken behind it

module multi_stack_shared_pool
    import msp_pkg::*;
#(
    parameter int NUM_STACKS = DEF_NUM_STACKS,
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request channel
    input  wire logic                    i_valid,
    output      logic                    o_ready,
    input  wire logic                    i_mode,
    input  wire logic [SEL_W-1:0]        i_stack_sel,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    // result channel
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      logic signed [VAL_W-1:0] o_pop_value,
    output      logic [STATUS_W-1:0]     o_status,
    output      logic                    o_stack_empty
);

    localparam int AW = $clog2(POOL_DEPTH);

    t_mem_ctl              w_mem_ctl;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [AW:0]           w_wr_link;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [AW:0]           w_rd_link;

    logic                  w_out_free;
    logic                  w_res_load;
    t_result               w_res;

    // output register
    logic                  r_out_valid;
    t_result               r_res;

    // the result register frees up when empty or when its result is taken this cycle
    assign w_out_free = !r_out_valid || i_ready;

    msp_ctrl #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .i_out_free   (w_out_free),
        .o_res_load   (w_res_load),
        .o_res        (w_res),
        .o_mem_ctl    (w_mem_ctl),
        .o_rd_addr    (w_rd_addr),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_wr_link    (w_wr_link),
        .i_rd_data    (w_rd_data),
        .i_rd_link    (w_rd_link)
    );

    // slot pool: values plus next-slot links, shared by every stack and the free list
    msp_pool_mem #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_pool (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_wr_link (w_wr_link),
        .o_rd_data (w_rd_data),
        .o_rd_link (w_rd_link)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pop_value   = r_res.pop_value;
    assign o_status      = r_res.status;
    assign o_stack_empty = r_res.stack_empty;

    // only one request in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in flight");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // underflow answers with an empty stack and all-ones value
    a_underflow_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_UNDERFLOW) |-> (o_stack_empty && o_pop_value == -1))
        else $error("malformed underflow result");

    // pool writes never coincide with a read issue
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.rd_en |-> !(w_mem_ctl.data_we || w_mem_ctl.link_we))
        else $error("pool read and write in the same cycle");

endmodule

`default_nettype wire

FILE: tb/sv/msp_tb_pkg.sv
`default_nettype none

package msp_tb_pkg;

    import msp_pkg::*;

    localparam int IDX_W = $clog2(DEF_POOL_DEPTH);

    // slot pointer with a live bit, null when live is low
    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             live;
    } t_slot_link;

    class stack_pool_scoreboard;

        logic [DEF_DATA_WIDTH-1:0] slot_data [DEF_POOL_DEPTH];
        t_slot_link                slot_next [DEF_POOL_DEPTH];
        t_slot_link                top_of [DEF_NUM_STACKS];
        t_slot_link                free_top;
        t_result                   due_results [$];
        int                        mismatches;

        function new();
            for (int i = 0; i < DEF_POOL_DEPTH; i++) begin
                slot_data[i]      = '0;
                slot_next[i].idx  = IDX_W'(i + 1);
                slot_next[i].live = (i + 1 < DEF_POOL_DEPTH);
            end
            for (int i = 0; i < DEF_NUM_STACKS; i++) begin
                top_of[i].idx  = '0;
                top_of[i].live = 1'b0;
            end
            free_top.idx  = '0;
            free_top.live = 1'b1;
            mismatches    = 0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        function int pending();
            return due_results.size();
        endfunction

        // walk the pool for one accepted request and queue what the block must answer
        function void note_request(logic mode, logic [SEL_W-1:0] sel,
                                   logic signed [VAL_W-1:0] value);
            t_result          r;
            logic [IDX_W-1:0] s;
            bit               present;
            r.pop_value   = '0;
            r.status      = ST_OK;
            r.stack_empty = 1'b1;
            present       = int'(sel) < DEF_NUM_STACKS;
            if (mode == MODE_PUSH) begin
                if (!present || !free_top.live) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    s              = free_top.idx;
                    free_top       = slot_next[s];
                    slot_data[s]   = DEF_DATA_WIDTH'(value);
                    slot_next[s]   = top_of[sel];
                    top_of[sel].idx  = s;
                    top_of[sel].live = 1'b1;
                end
            end else begin
                if (!present || !top_of[sel].live) begin
                    r.status    = ST_UNDERFLOW;
                    r.pop_value = '1;
                end else begin
                    s             = top_of[sel].idx;
                    r.pop_value   = VAL_W'($signed(slot_data[s]));
                    top_of[sel]   = slot_next[s];
                    slot_next[s]  = free_top;
                    free_top.idx  = s;
                    free_top.live = 1'b1;
                end
            end
            if (present) r.stack_empty = !top_of[sel].live;
            due_results.push_back(r);
        endfunction

        task check_result(logic [VAL_W-1:0] pop_value, logic [STATUS_W-1:0] status,
                          logic stack_empty);
            t_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing due: value %h status %0d",
                                          pop_value, status));
                return;
            end
            want = due_results.pop_front();
            if (pop_value !== want.pop_value)
                report_mismatch($sformatf("pop_value %h, want %h", pop_value, want.pop_value));
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (stack_empty !== want.stack_empty)
                report_mismatch($sformatf("stack_empty %b, want %b",
                                          stack_empty, want.stack_empty));
        endtask

    endclass

endpackage

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;
    import msp_tb_pkg::*;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic                    i_mode       = MODE_PUSH;
    logic [SEL_W-1:0]        i_stack_sel  = '0;
    logic signed [VAL_W-1:0] i_push_value = '0;
    logic                    i_ready      = 1'b0;
    wire logic                    o_ready;
    wire logic                    o_valid;
    wire logic signed [VAL_W-1:0] o_pop_value;
    wire logic [STATUS_W-1:0]     o_status;
    wire logic                    o_stack_empty;

    // idling knobs, percentages of cycles
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_off_cycles = 0;

    stack_pool_scoreboard sb = new();

    multi_stack_shared_pool uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_stack_sel   (i_stack_sel),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_stack_empty (o_stack_empty)
    );

    always #4 i_clk = ~i_clk;

    // result side back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // every accepted result goes against the oldest due one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_pop_value, o_status, o_stack_empty);
    end

    // mostly uniform values, now and then one of the extremes
    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // offer one request from a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic mode, input logic [SEL_W-1:0] sel,
                                input logic signed [VAL_W-1:0] value);
        // random gaps before the request goes up
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_stack_sel  <= sel;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(mode, sel, value);
        @(negedge i_clk);
    endtask

    // a run of random requests, biased towards push or pop to sweep the pool fill level
    task automatic run_phase(input int idle_pct, input int stall_pct, input int push_pct,
                             input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            send_request(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP,
                         SEL_W'($urandom_range(3)), random_value());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // underflow on every empty stack
        for (int k = 0; k < 4; k++) send_request(MODE_POP, SEL_W'(k), $urandom());
        // extremes of the value range, popped back in reverse order
        send_request(MODE_PUSH, SEL_W'(0), 32'sh7fff_ffff);
        send_request(MODE_PUSH, SEL_W'(3), 32'sh8000_0000);
        send_request(MODE_POP,  SEL_W'(3), '0);
        send_request(MODE_POP,  SEL_W'(0), '1);
        // fill the whole pool across all stacks, then overflow
        for (int k = 0; k < DEF_POOL_DEPTH; k++)
            send_request(MODE_PUSH, SEL_W'(k % 4), $urandom());
        send_request(MODE_PUSH, SEL_W'(1), 32'sh7fff_ffff);

        run_phase(0,  0,  35, 120);
        run_phase(67, 0,  65, 120);
        run_phase(0,  67, 40, 120);
        run_phase(17, 17, 60, 120);
        // receiver holds off while requests keep coming, so the block backs up
        hold_off_cycles = 300;
        run_phase(0,  0,  50, 60);
        run_phase(0,  0,  45, 110);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("multi_stack_shared_pool verification clean");
        end else begin
            $display("multi_stack_shared_pool verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("multi_stack_shared_pool verification failed");
        $finish;
    end

endmodule

`default_nettype wire
